[hdl/grouped_timer_pool_defines.svh]
// assertion macros for the timer pool
`ifndef GROUPED_TIMER_POOL_DEFINES_SVH
`define GROUPED_TIMER_POOL_DEFINES_SVH
`ifndef ASSERT_OFF
`define GTP_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define GTP_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define GTP_ASSERT_IMP(label, clk, rst, a, c, msg)
`define GTP_ASSERT_NXT(label, clk, rst, a, c, msg)
`endif
`endif

[hdl/gtp_pkg.sv]
// ----------------------------------------------------------------------------
// gtp_pkg
// shared types and codes of the timer pool
// ----------------------------------------------------------------------------
package gtp_pkg;
  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] KIND_CREATED   = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_CANCELLED = 3'd2;
  localparam logic [2:0] KIND_EXPIRED   = 3'd3;
  localparam logic [2:0] KIND_DONE      = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] interval;
    logic        recurring;
    logic [3:0]  timer_id;
    logic [15:0] delta;
  } cmd_t;
endpackage

[hdl/gtp_if.sv]
// ----------------------------------------------------------------------------
// gtp_in_if / gtp_out_if
// valid/ready channels of the timer pool
// ----------------------------------------------------------------------------
interface gtp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] interval;
  logic        recurring;
  logic [3:0]  timer_id;
  logic [15:0] delta;
  modport source (output valid, mode, interval, recurring, timer_id, delta, input ready);
  modport sink (input valid, mode, interval, recurring, timer_id, delta, output ready);
endinterface

interface gtp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [3:0] slot;
  logic       last;
  modport source (output valid, kind, slot, last, input ready);
  modport sink (input valid, kind, slot, last, output ready);
endinterface

[hdl/grouped_timer_pool.sv]
// ----------------------------------------------------------------------------
// grouped_timer_pool
// pool of grouped timers with create, cancel and tick commands
// ----------------------------------------------------------------------------
// a create or cancel word gives one result word, which passes the queue and
// the back end and is offered from the output register; the back end takes
// one such word per cycle while out.ready does not stall it; a tick walks
// every slot one per cycle through the shared saturating adder, except while
// an expiry word waits on out.ready, holds the back end for the pop, the
// slot walk and the done word, and ends with a done word; a two-entry queue
// lets words arrive while the back end is busy; the group register may only
// be written while the pool is idle
module grouped_timer_pool import gtp_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  gtp_in_if.sink     in,
  gtp_out_if.source  out
);
`include "grouped_timer_pool_defines.svh"
  logic [7:0] cur_group;
  logic       q_valid, q_pop;
  cmd_t       q_cmd;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) cur_group <= 8'd0;
    else if (cfg_we) cur_group <= cfg_wdata;
  end

  // front end: accept and queue words
  gtp_front u_front (.clk, .rst, .in, .q_valid, .q_pop, .q_cmd);

  // back end: timer state and tick walk
  gtp_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk, .rst, .cur_group, .q_valid, .q_pop, .q_cmd, .out);

  // a pop only happens with an entry queued
  `GTP_ASSERT_IMP(a_pop_valid, clk, rst, q_pop, q_valid, "pop from empty queue")
  // a stalled output word holds its kind
  `GTP_ASSERT_NXT(a_out_hold, clk, rst, out.valid && !out.ready,
    out.valid && $stable(out.kind), "output word changed while stalled")
  // created and cancelled words always end their item
  `GTP_ASSERT_IMP(a_last, clk, rst, out.valid && (out.kind == KIND_CREATED ||
    out.kind == KIND_CANCELLED || out.kind == KIND_DONE), out.last, "missing last")
endmodule

[hdl/gtp_front.sv]
// ----------------------------------------------------------------------------
// gtp_front
// takes input words, drops unused mode, two-entry queue to the back end
// ----------------------------------------------------------------------------
module gtp_front import gtp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  gtp_in_if.sink  in,
  output logic    q_valid,
  input  logic    q_pop,
  output cmd_t    q_cmd
);
  cmd_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, keep;

  assign in.ready = (count != 2'd2);
  assign keep     = (in.mode == MODE_CREATE) || (in.mode == MODE_CANCEL) ||
                    (in.mode == MODE_TICK);
  assign push     = in.valid && in.ready && keep;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{mode: in.mode, interval: in.interval, recurring: in.recurring,
                       timer_id: in.timer_id, delta: in.delta};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

[hdl/gtp_back.sv]
// ----------------------------------------------------------------------------
// gtp_back
// timer state and sequencer that carries out create, cancel and tick
// ----------------------------------------------------------------------------
module gtp_back import gtp_pkg::*; #(
  parameter int NUM_TIMERS = 16,
  parameter int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  logic      clk,
  input  logic      rst,
  input  logic [7:0] cur_group,
  input  logic      q_valid,
  output logic      q_pop,
  input  cmd_t      q_cmd,
  gtp_out_if.source out
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;
  state_t          state;
  logic [NUM_TIMERS-1:0] alive;
  logic            rep   [NUM_TIMERS];
  logic [7:0]      grp   [NUM_TIMERS];
  logic [31:0]     ivl   [NUM_TIMERS];
  logic [31:0]     ela   [NUM_TIMERS];
  logic [IW-1:0]   idx;
  logic [15:0]     delta;
  logic            free_found;
  logic [IW-1:0]   free_idx;
  logic [32:0]     sum_w;
  logic [31:0]     sum;
  logic            served, expire;
  logic            obusy;
  logic            emit;

  assign obusy = out.valid && !out.ready;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!alive[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  assign sum_w  = {1'b0, ela[idx]} + {17'd0, delta};
  assign sum    = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
  assign served = alive[idx] && ((grp[idx] == 8'd0) || (grp[idx] == cur_group));
  assign expire = served && (sum >= ivl[idx]);
  assign q_pop  = (state == S_IDLE) && q_valid && !obusy;

  // a new output word is loaded this cycle
  assign emit = (q_pop && ((q_cmd.mode == MODE_CREATE) || (q_cmd.mode == MODE_CANCEL))) ||
                ((state == S_SCAN) && !obusy && expire) ||
                ((state == S_DONE) && !obusy);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      alive     <= '0;
      out.valid <= 1'b0;
      idx       <= '0;
    end else begin
      out.valid <= emit || obusy;
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            out.last <= 1'b1;
            case (q_cmd.mode)
              MODE_CREATE: begin
                if (free_found) begin
                  alive[free_idx] <= 1'b1;
                  rep[free_idx]   <= q_cmd.recurring;
                  grp[free_idx]   <= cur_group;
                  ivl[free_idx]   <= q_cmd.interval;
                  ela[free_idx]   <= '0;
                  out.kind        <= KIND_CREATED;
                  out.slot        <= 4'(free_idx);
                end else begin
                  out.kind <= KIND_FULL;
                  out.slot <= 4'd0;
                end
              end
              MODE_CANCEL: begin
                if (32'(q_cmd.timer_id) < NUM_TIMERS) alive[IW'(q_cmd.timer_id)] <= 1'b0;
                out.kind <= KIND_CANCELLED;
                out.slot <= q_cmd.timer_id;
              end
              default: begin
                delta <= q_cmd.delta;
                idx   <= '0;
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!obusy) begin
            if (served) begin
              ela[idx] <= expire && rep[idx] ? sum - ivl[idx] : sum;
              if (expire) begin
                if (!rep[idx]) alive[idx] <= 1'b0;
                out.kind  <= KIND_EXPIRED;
                out.slot  <= 4'(idx);
                out.last  <= 1'b0;
              end
            end
            if (32'(idx) == NUM_TIMERS - 1) state <= S_DONE;
            else idx <= idx + 1'b1;
          end
        end
        S_DONE: begin
          if (!obusy) begin
            out.kind  <= KIND_DONE;
            out.slot  <= 4'd0;
            out.last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[verif/tb_grouped_timer_pool.sv]
// ----------------------------------------------------------------------------
// tb_grouped_timer_pool
// drives create, cancel and tick words into the timer pool under random idling
// on both channels, predicts every result word and compares it field by field
// ----------------------------------------------------------------------------
module tb_grouped_timer_pool;
  timeunit 1ns;
  timeprecision 1ps;
  import gtp_pkg::*;

  localparam int NTIM = 16;
  localparam int NRAND = 372;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot;
    logic       last;
  } res_t;

  // directed row: command plus an optional typed-in result, checked against the last predicted word
  typedef struct {
    cmd_t cmd;
    bit   has_exp;
    res_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  gtp_in_if  in_ch();
  gtp_out_if out_ch();

  grouped_timer_pool u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in(in_ch.sink), .out(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the pool
  logic [7:0]  grp_sh;
  bit          alive_sh [NTIM];
  bit          rep_sh   [NTIM];
  logic [7:0]  tag_sh   [NTIM];
  logic [31:0] ival_sh  [NTIM];
  logic [31:0] el_sh    [NTIM];

  res_t pending_res[$];
  int   errors = 0;
  bit   no_idle = 1'b0;
  bit   hold_off = 1'b0;

  // predictor: push the result words one command causes
  task automatic predict_cmd(input cmd_t c);
    int i;
    logic [32:0] sum;
    bit found;
    found = 1'b0;
    case (c.mode)
      MODE_CREATE: begin
        for (i = 0; i < NTIM && !found; i++) if (!alive_sh[i]) begin
          found = 1'b1;
          alive_sh[i] = 1'b1;
          rep_sh[i] = c.recurring;
          tag_sh[i] = grp_sh;
          ival_sh[i] = c.interval;
          el_sh[i] = '0;
          pending_res.push_back('{KIND_CREATED, 4'(i), 1'b1});
        end
        if (!found) pending_res.push_back('{KIND_FULL, 4'd0, 1'b1});
      end
      MODE_CANCEL: begin
        alive_sh[c.timer_id] = 1'b0;
        pending_res.push_back('{KIND_CANCELLED, c.timer_id, 1'b1});
      end
      MODE_TICK: begin
        for (i = 0; i < NTIM; i++) begin
          if (!alive_sh[i]) continue;
          if (tag_sh[i] != 8'd0 && tag_sh[i] != grp_sh) continue;
          sum = {1'b0, el_sh[i]} + c.delta;
          el_sh[i] = sum[32] ? 32'hffff_ffff : sum[31:0];
          if (el_sh[i] >= ival_sh[i]) begin
            pending_res.push_back('{KIND_EXPIRED, 4'(i), 1'b0});
            if (rep_sh[i]) el_sh[i] = el_sh[i] - ival_sh[i];
            else alive_sh[i] = 1'b0;
          end
        end
        pending_res.push_back('{KIND_DONE, 4'd0, 1'b1});
      end
      default: ;  // unused mode gives nothing
    endcase
  endtask

  // typed-in result of a single-word item against the predictor
  task automatic check_typed(input res_t e);
    if (pending_res.size() == 0) begin
      $error("typed result: expected %0h, nothing predicted", e);
      errors++;
    end else if (pending_res[$] != e) begin
      $error("typed result: expected %0h, predicted %0h", e, pending_res[$]);
      errors++;
    end
  endtask

  // one word on the input channel, with random idle ahead of it
  task automatic send_word(input cmd_t c);
    while (!no_idle && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= c.mode;
    in_ch.interval <= c.interval;
    in_ch.recurring <= c.recurring;
    in_ch.timer_id <= c.timer_id;
    in_ch.delta <= c.delta;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_cmd(c);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_group(input logic [7:0] g);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    grp_sh = g;
  endtask

  function automatic cmd_t mk(input logic [1:0] m, input logic [31:0] iv,
                              input logic r, input logic [3:0] id,
                              input logic [15:0] d);
    cmd_t c;
    c.mode = m; c.interval = iv; c.recurring = r; c.timer_id = id; c.delta = d;
    return c;
  endfunction

  // random word: mostly creates and ticks
  function automatic cmd_t rand_cmd();
    int p;
    logic [31:0] iv;
    p = $urandom_range(99);
    case ($urandom_range(3))
      0: iv = $urandom;
      1: iv = $urandom_range(200);
      default: iv = $urandom_range(70000);
    endcase
    if (p < 35) return mk(MODE_CREATE, iv, 1'($urandom_range(1)), 4'($urandom),
                          16'($urandom));
    if (p < 55) return mk(MODE_CANCEL, $urandom, 1'($urandom_range(1)), 4'($urandom),
                          16'($urandom));
    if (p < 97) return mk(MODE_TICK, $urandom, 1'($urandom_range(1)), 4'($urandom),
                          ($urandom_range(9) == 0) ? 16'hffff : 16'($urandom_range(300)));
    return mk(MODE_UNUSED, $urandom, 1'($urandom_range(1)), 4'($urandom), 16'($urandom));
  endfunction

  // output side: random stall, long hold-off on request, compare each word
  initial begin
    res_t got, want;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= 18);
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.kind, out_ch.slot, out_ch.last};
        if (pending_res.size() == 0) begin
          $error("result word with nothing expected: kind %0d slot %0d", got.kind, got.slot);
          errors++;
        end else begin
          want = pending_res.pop_front();
          if (got.kind != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind); errors++;
          end
          if (got.slot != want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot); errors++;
          end
          if (got.last != want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last); errors++;
          end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // main sequence
  initial begin
    row_t rows[$];
    row_t r;
    int i;
    int k;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_CREATE;
    in_ch.interval = '0;
    in_ch.recurring = 1'b0;
    in_ch.timer_id = '0;
    in_ch.delta = '0;
    grp_sh = '0;
    foreach (alive_sh[i]) begin
      alive_sh[i] = 0; rep_sh[i] = 0; tag_sh[i] = 0; ival_sh[i] = 0; el_sh[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: first create after reset, zero interval, max interval,
    // cancel of free slot and of the last slot, unused mode, maximum-delta tick
    rows.push_back('{mk(MODE_CREATE, 32'd0, 1'b1, 4'd0, 16'd0), 1, '{KIND_CREATED, 4'd0, 1'b1}});
    rows.push_back('{mk(MODE_CREATE, 32'hffff_ffff, 1'b0, 4'd0, 16'd0), 1,
                     '{KIND_CREATED, 4'd1, 1'b1}});
    rows.push_back('{mk(MODE_CREATE, 32'd100, 1'b0, 4'd0, 16'd0), 1,
                     '{KIND_CREATED, 4'd2, 1'b1}});
    rows.push_back('{mk(MODE_TICK, 32'd0, 1'b0, 4'd0, 16'd0), 0, '{3'd0, 4'd0, 1'b0}});
    rows.push_back('{mk(MODE_TICK, 32'd0, 1'b0, 4'd0, 16'hffff), 0, '{3'd0, 4'd0, 1'b0}});
    rows.push_back('{mk(MODE_CANCEL, 32'd0, 1'b0, 4'd9, 16'd0), 1,
                     '{KIND_CANCELLED, 4'd9, 1'b1}});
    rows.push_back('{mk(MODE_CANCEL, 32'd0, 1'b0, 4'd15, 16'd0), 1,
                     '{KIND_CANCELLED, 4'd15, 1'b1}});
    rows.push_back('{mk(MODE_UNUSED, 32'hffff_ffff, 1'b1, 4'd15, 16'hffff), 0,
                     '{3'd0, 4'd0, 1'b0}});
    for (i = 0; i < 15; i++)
      rows.push_back('{mk(MODE_CREATE, 32'(i * 3), 1'(i), 4'd0, 16'd0), 0, '{3'd0, 4'd0, 1'b0}});
    rows.push_back('{mk(MODE_TICK, 32'd0, 1'b0, 4'd0, 16'd40), 0, '{3'd0, 4'd0, 1'b0}});
    foreach (rows[i]) begin
      send_word(rows[i].cmd);
      if (rows[i].has_exp) check_typed(rows[i].exp);
    end
    wait_drain();

    // pool full: fill up then check the full report
    write_group(8'hff);
    for (i = 0; i < NTIM + 1; i++) send_word(mk(MODE_CREATE, 32'd5, 1'b1, 4'd0, 16'd0));
    send_word(mk(MODE_CREATE, 32'd5, 1'b1, 4'd0, 16'd0));
    check_typed('{KIND_FULL, 4'd0, 1'b1});
    // block fills while the receiver holds off
    hold_off = 1'b1;
    no_idle = 1'b1;
    for (i = 0; i < 8; i++) send_word(mk(MODE_TICK, 32'd0, 1'b0, 4'd0, 16'd7));
    wait_drain();

    // random phases over several group settings
    for (k = 0; k < 6; k++) begin
      case (k)
        0: write_group(8'd0);
        1: write_group(8'd1);
        2: write_group(8'd255);
        default: write_group(8'($urandom_range(3)));
      endcase
      no_idle = (k == 3);
      for (i = 0; i < NRAND / 6; i++) send_word(rand_cmd());
      wait_drain();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
